FILE: hw/rtl/owrs_pkg.sv
// Shared types and constants for the 1-Wire ROM search decision core.
`timescale 1ns / 1ps
`default_nettype none

package owrs_pkg;

    // ROM id geometry
    localparam int unsigned ROM_ID_W     = 64;
    localparam int unsigned BIT_POS_W    = 6;   // index into the ROM id, 0..63
    localparam int unsigned BIT_IDX_W    = 7;   // one-based bit number, 1..64
    localparam int unsigned FAM_DISC_W   = 4;
    localparam int unsigned FAMILY_LIMIT = 9;   // family code is bits 1..8

    localparam logic [BIT_IDX_W-1:0] FIRST_BIT = BIT_IDX_W'(1);
    localparam logic [BIT_IDX_W-1:0] LAST_BIT  = BIT_IDX_W'(ROM_ID_W);

    typedef enum logic [1:0] {
        ACT_START     = 2'd0,
        ACT_BIT_PAIR  = 2'd1,
        ACT_READ_FAIL = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        ST_IGNORED  = 3'd0,
        ST_STARTED  = 3'd1,
        ST_CONTINUE = 3'd2,
        ST_FOUND    = 3'd3,
        ST_FAILED   = 3'd4
    } t_status;

endpackage

`default_nettype wire

FILE: hw/rtl/one_wire_rom_search_unit.sv
// Top level of the 1-Wire ROM search decision core.
//
//  channel | valid       | stall       | payload
//  --------+-------------+-------------+-------------------------------------------
//  in      | i_in_valid  | o_in_stall  | i_action, i_presence, i_id_bit, i_compl_bit
//  out     | o_out_valid | i_out_stall | o_status, o_write_valid, o_write_bit,
//          |             |             | o_rom_id, o_last_device, o_family_discrepancy
//
// Each item passes through the input register and then the result register.
// One item per cycle is sustained while the output does not stall; the
// decision logic between the two registers is a single 64:1 bit select plus
// a few 7-bit compares. Reset (i_rst_n, synchronous) clears both pipeline
// valids and all search state. A stall on the output holds the result
// register and, once the input register is also full, raises o_in_stall.
`timescale 1ns / 1ps
`default_nettype none

module one_wire_rom_search_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [1:0]                    i_action,
    input  wire logic                          i_presence,
    input  wire logic                          i_id_bit,
    input  wire logic                          i_compl_bit,
    // result channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [2:0]                         o_status,
    output logic                               o_write_valid,
    output logic                               o_write_bit,
    output logic [owrs_pkg::ROM_ID_W-1:0]      o_rom_id,
    output logic                               o_last_device,
    output logic [owrs_pkg::FAM_DISC_W-1:0]    o_family_discrepancy
);
    import owrs_pkg::*;

    // ------------------------------------------------------------------
    // Pipeline registers
    // ------------------------------------------------------------------
    logic                    r_in_valid;
    logic [1:0]              r_action;
    logic                    r_presence;
    logic                    r_id_bit;
    logic                    r_compl_bit;

    logic                    r_out_valid;
    t_status                 r_out_status;
    logic                    r_out_wvalid;
    logic                    r_out_wbit;
    logic [ROM_ID_W-1:0]     r_out_rom_id;
    logic                    r_out_last_dev;
    logic [FAM_DISC_W-1:0]   r_out_family;

    // ------------------------------------------------------------------
    // Search state
    // ------------------------------------------------------------------
    logic [ROM_ID_W-1:0]     r_rom_bits,   n_rom_bits;
    logic [BIT_IDX_W-1:0]    r_last_disc,  n_last_disc;
    logic [FAM_DISC_W-1:0]   r_family,     n_family;
    logic                    r_last_dev,   n_last_dev;
    logic [BIT_IDX_W-1:0]    r_bit_index,  n_bit_index;
    logic [BIT_IDX_W-1:0]    r_zero_mark,  n_zero_mark;
    logic                    r_active,     n_active;

    // decision results for the item in the input register
    t_status                 n_status;
    logic                    n_wvalid;
    logic                    n_wbit;
    logic [ROM_ID_W-1:0]     n_rom_out;

    logic                    advance;      // input register moves to result register
    logic                    in_xfer;
    logic                    dir;
    logic [BIT_POS_W-1:0]    pos;

    // The result register frees when empty or taken this cycle.
    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !advance;
    assign in_xfer    = i_in_valid && !o_in_stall;

    assign pos = r_bit_index[BIT_POS_W-1:0] - BIT_POS_W'(1);

    // Direction choice: forced by a 0/1 or 1/0 pair; on a discrepancy follow
    // the previous path below the last discrepancy, take 1 at it, 0 beyond.
    always_comb begin
        if (r_id_bit != r_compl_bit) begin
            dir = r_id_bit;
        end else if (r_bit_index < r_last_disc) begin
            dir = r_rom_bits[pos];
        end else begin
            dir = (r_bit_index == r_last_disc);
        end
    end

    always_comb begin
        n_rom_bits  = r_rom_bits;
        n_last_disc = r_last_disc;
        n_family    = r_family;
        n_last_dev  = r_last_dev;
        n_bit_index = r_bit_index;
        n_zero_mark = r_zero_mark;
        n_active    = r_active;
        n_status    = ST_IGNORED;
        n_wvalid    = 1'b0;
        n_wbit      = 1'b0;
        n_rom_out   = '0;

        case (t_action'(r_action))
            ACT_START: begin
                if (!r_presence || r_last_dev) begin
                    n_status = ST_FAILED;
                end else begin
                    n_active    = 1'b1;
                    n_bit_index = FIRST_BIT;
                    n_zero_mark = '0;
                    n_status    = ST_STARTED;
                end
            end
            ACT_BIT_PAIR: begin
                if (r_active) begin
                    if (r_id_bit && r_compl_bit) begin
                        n_status = ST_FAILED;   // no device answered
                    end else begin
                        if (r_id_bit == r_compl_bit && !dir) begin
                            n_zero_mark = r_bit_index;
                            if (r_bit_index < BIT_IDX_W'(FAMILY_LIMIT)) begin
                                n_family = r_bit_index[FAM_DISC_W-1:0];
                            end
                        end
                        n_rom_bits[pos] = dir;
                        n_wvalid        = 1'b1;
                        n_wbit          = dir;
                        n_bit_index     = r_bit_index + BIT_IDX_W'(1);
                        n_status        = ST_CONTINUE;
                        if (r_bit_index == LAST_BIT) begin
                            n_last_disc = n_zero_mark;
                            if (n_zero_mark == '0) begin
                                n_last_dev = 1'b1;
                            end
                            if (n_rom_bits[7:0] == 8'd0) begin
                                n_status = ST_FAILED;   // all-zero family code
                            end else begin
                                n_rom_out   = n_rom_bits;
                                n_active    = 1'b0;
                                n_bit_index = FIRST_BIT;
                                n_status    = ST_FOUND;
                            end
                        end
                    end
                end
            end
            ACT_READ_FAIL: begin
                if (r_active) begin
                    n_status = ST_FAILED;
                end
            end
            default: begin
                n_status = ST_IGNORED;
            end
        endcase

        // any failure wipes the search state
        if (n_status == ST_FAILED) begin
            n_rom_bits  = '0;
            n_last_disc = '0;
            n_family    = '0;
            n_last_dev  = 1'b0;
            n_bit_index = FIRST_BIT;
            n_zero_mark = '0;
            n_active    = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_rom_bits  <= '0;
            r_last_disc <= '0;
            r_family    <= '0;
            r_last_dev  <= 1'b0;
            r_bit_index <= FIRST_BIT;
            r_zero_mark <= '0;
            r_active    <= 1'b0;
        end else begin
            // an empty input register takes a transfer even while the output stalls
            r_in_valid <= in_xfer || (r_in_valid && !advance);
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (advance && r_in_valid) begin
                r_rom_bits  <= n_rom_bits;
                r_last_disc <= n_last_disc;
                r_family    <= n_family;
                r_last_dev  <= n_last_dev;
                r_bit_index <= n_bit_index;
                r_zero_mark <= n_zero_mark;
                r_active    <= n_active;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_action     <= i_action;
            r_presence   <= i_presence;
            r_id_bit     <= i_id_bit;
            r_compl_bit  <= i_compl_bit;
        end
        if (advance && r_in_valid) begin
            r_out_status   <= n_status;
            r_out_wvalid   <= n_wvalid;
            r_out_wbit     <= n_wbit;
            r_out_rom_id   <= n_rom_out;
            r_out_last_dev <= n_last_dev;
            r_out_family   <= n_family;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_status             = r_out_status;
    assign o_write_valid        = r_out_wvalid;
    assign o_write_bit          = r_out_wbit;
    assign o_rom_id             = r_out_rom_id;
    assign o_last_device        = r_out_last_dev;
    assign o_family_discrepancy = r_out_family;

`ifndef SYNTHESIS
    // a found id never carries a zero family byte
    a_found_nonzero_family: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == ST_FOUND) |-> (r_out_rom_id[7:0] != 8'd0))
        else $error("found ROM id with zero family byte");

    // while searching the bit number stays within the id
    a_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_bit_index >= FIRST_BIT && r_bit_index <= LAST_BIT))
        else $error("bit index out of range during search");

    // idle means rewound to the first bit
    a_idle_rewound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active |-> (r_bit_index == FIRST_BIT))
        else $error("bit index not rewound while idle");

    // a failure leaves the search state cleared
    a_fail_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_valid && n_status == ST_FAILED)
            |=> (!r_active && !r_last_dev && r_rom_bits == '0 && r_last_disc == '0))
        else $error("search state not cleared after failure");
`endif

endmodule

`default_nettype wire
